// ----- src/plf_pkg.sv -----
// Package for the prefixed line filter.
// Holds shared widths, byte codes, register indexes, line phase type and queue entry type.
package plf_pkg;

	localparam int BYTE_W = 8;
	localparam int LEN_W  = 10;

	localparam logic [BYTE_W-1:0] LF_BYTE = 8'h0A;
	localparam logic [BYTE_W-1:0] CR_BYTE = 8'h0D;

	localparam logic [LEN_W-1:0]  MAX_CHARS_RST = 10'd255;
	localparam logic [BYTE_W-1:0] PREFIX_RST    = 8'h23;

	typedef enum logic {
		CFG_MAX_CHARS = 1'b0,
		CFG_PREFIX    = 1'b1
	} cfg_idx_t;

	typedef enum logic {
		KIND_BYTE = 1'b0,
		KIND_END  = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		PH_START  = 3'b001,
		PH_ACCEPT = 3'b010,
		PH_REJECT = 3'b100
	} phase_t;

	typedef struct packed {
		logic [LEN_W-1:0]  max_chars;
		logic [BYTE_W-1:0] prefix_char;
	} cfg_t;

	// One queue entry holds what one input byte causes: a kept byte, an end marker, or both.
	typedef struct packed {
		logic              has_byte;
		logic [BYTE_W-1:0] byte_val;
		logic              has_end;
		logic [LEN_W-1:0]  len;
	} entry_t;

	typedef struct packed {
		logic   empty;
		entry_t head;
	} q_status_t;

endpackage

// ----- src/plf_if.sv -----
// Channel interfaces for the prefixed line filter.
// Depends on plf_pkg for field widths.
interface plf_byte_if import plf_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface plf_result_if import plf_pkg::*; ;
	logic              valid;
	logic              ready;
	logic              kind;
	logic [BYTE_W-1:0] out_byte;
	logic [LEN_W-1:0]  line_length;

	modport source (output valid, output kind, output out_byte, output line_length, input ready);
	modport sink (input valid, input kind, input out_byte, input line_length, output ready);
endinterface

// ----- src/plf_front.sv -----
// Front part: accepts received bytes, tracks the line phase and the hold register.
// Depends on plf_pkg and plf_byte_if; pushes result entries into the queue.
module plf_front import plf_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	plf_byte_if.sink      rx,
	input  cfg_t          cfg,
	input  logic          full,
	output logic          push,
	output entry_t        push_entry
);

	phase_t            phase_q, phase_d;
	logic [LEN_W-1:0]  kept_q, kept_d;
	logic [BYTE_W-1:0] held_q, held_d;
	logic              held_valid_q, held_valid_d;
	logic              accept;
	logic              cr_drop;

	assign rx.ready = !full;
	assign accept   = rx.valid && !full;
	assign cr_drop  = held_valid_q && (held_q == CR_BYTE);

	always_comb begin
		phase_d      = phase_q;
		kept_d       = kept_q;
		held_d       = held_q;
		held_valid_d = held_valid_q;
		push         = 1'b0;
		push_entry   = '0;
		if (rx.rx_byte == LF_BYTE) begin
			if (phase_q == PH_ACCEPT) begin
				push                = accept;
				push_entry.has_byte = held_valid_q && !cr_drop;
				push_entry.byte_val = held_q;
				push_entry.has_end  = 1'b1;
				push_entry.len      = kept_q - LEN_W'(cr_drop);
			end
			phase_d      = PH_START;
			kept_d       = '0;
			held_valid_d = 1'b0;
		end else begin
			unique case (phase_q)
				PH_START: begin
					if (rx.rx_byte == cfg.prefix_char) begin
						phase_d = PH_ACCEPT;
						if (cfg.max_chars != '0) begin
							held_d       = rx.rx_byte;
							held_valid_d = 1'b1;
							kept_d       = LEN_W'(1);
						end
					end else begin
						phase_d = PH_REJECT;
					end
				end
				PH_ACCEPT: begin
					if (kept_q < cfg.max_chars) begin
						push                = accept && held_valid_q;
						push_entry.has_byte = 1'b1;
						push_entry.byte_val = held_q;
						held_d              = rx.rx_byte;
						held_valid_d        = 1'b1;
						kept_d              = kept_q + LEN_W'(1);
					end
				end
				PH_REJECT: begin
				end
				default: begin
					phase_d = PH_REJECT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_START;
			kept_q       <= '0;
			held_valid_q <= 1'b0;
		end else if (accept) begin
			phase_q      <= phase_d;
			kept_q       <= kept_d;
			held_valid_q <= held_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_q <= held_d;
		end
	end

endmodule

// ----- src/plf_queue.sv -----
// Short queue of result entries between the front and back parts.
// Depends on plf_pkg for the entry type.
module plf_queue import plf_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  entry_t    push_entry,
	input  logic      pop,
	output logic      full,
	output q_status_t status
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t         slots_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full          = (count_q == CW'(DEPTH));
	assign status.empty  = (count_q == '0);
	assign status.head   = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ----- src/plf_back.sv -----
// Back part: unpacks queue entries into result transactions through an output register.
// Depends on plf_pkg and plf_result_if.
module plf_back import plf_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  q_status_t     status,
	output logic          pop,
	plf_result_if.source  res
);

	logic              out_valid_q;
	logic              kind_q;
	logic [BYTE_W-1:0] byte_q;
	logic [LEN_W-1:0]  len_q;
	logic              byte_done_q;
	logic              load;
	logic              send_byte;

	assign load      = !status.empty && (!out_valid_q || res.ready);
	assign send_byte = status.head.has_byte && !byte_done_q;
	// An entry with both a byte and an end marker stays at the head for a second transaction.
	assign pop       = load && !(send_byte && status.head.has_end);

	assign res.valid       = out_valid_q;
	assign res.kind        = kind_q;
	assign res.out_byte    = byte_q;
	assign res.line_length = len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			byte_done_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				byte_done_q <= !pop;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (send_byte) begin
				kind_q <= KIND_BYTE;
				byte_q <= status.head.byte_val;
				len_q  <= '0;
			end else begin
				kind_q <= KIND_END;
				byte_q <= '0;
				len_q  <= status.head.len;
			end
		end
	end

endmodule

// ----- src/prefixed_line_filter_top.sv -----
// Top level of the prefixed line filter: configuration registers, front, queue and back.
// Depends on plf_pkg, plf_if, plf_front, plf_queue and plf_back.
//
//   channel   direction  payload                          handshake
//   rx        in         rx_byte                          valid/ready
//   res       out        kind, out_byte, line_length      valid/ready
//   cfg       in         cfg_index, cfg_data              cfg_we
//
// One byte is accepted per cycle while the queue has room; the front decides on each byte in
// the cycle it is accepted. The back sends one transaction per cycle while the queue is not
// empty and res is ready; a line end that also flushes the held byte needs two transactions.
// Reset clears the line state, the queue and the output register; registers take defaults.
// Output stalls fill the queue, which then lowers rx.ready.
module prefixed_line_filter_top import plf_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	plf_byte_if.sink          rx,
	plf_result_if.source      res,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [LEN_W-1:0]  cfg_data
);

	cfg_t      cfg_q;
	logic      full;
	logic      push;
	entry_t    push_entry;
	logic      pop;
	q_status_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_chars   <= MAX_CHARS_RST;
			cfg_q.prefix_char <= PREFIX_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MAX_CHARS: cfg_q.max_chars   <= cfg_data;
				CFG_PREFIX:    cfg_q.prefix_char <= cfg_data[BYTE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	plf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.cfg        (cfg_q),
		.full       (full),
		.push       (push),
		.push_entry (push_entry)
	);

	plf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (full),
		.status     (status)
	);

	plf_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.pop    (pop),
		.res    (res)
	);

	a_end_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && (res.kind == KIND_END) |-> res.out_byte == '0)
		else $error("end marker carries a nonzero byte");

	a_byte_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && (res.kind == KIND_BYTE) |-> res.line_length == '0)
		else $error("kept byte carries a nonzero length");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !status.empty)
		else $error("queue popped while empty");

	a_push_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> push_entry.has_byte || push_entry.has_end)
		else $error("queue entry pushed without a result");

endmodule
